@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SIU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SIU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/siu_pkg.sv @@
`timescale 1ns / 1ps
package siu_pkg;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_RENDER = 1'b1;

	localparam logic REG_SRC_WIDTH  = 1'b0;
	localparam logic REG_SRC_HEIGHT = 1'b1;

	// Coverage test: d2 * COV_MUL <= 2 * (COV_A * SCALE + COV_B - COV_STEP * k)^2
	localparam int COV_MUL  = 10240000;
	localparam int COV_A    = 3968;
	localparam int COV_B    = 3200;
	localparam int COV_STEP = 25;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic issue;
		logic lhs;
		logic srch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic geom_err;
		logic scan_last;
		logic pipe_busy;
		logic srch_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/siu_datapath.sv @@
`timescale 1ns / 1ps
module siu_datapath #(
	parameter int MAX_SOURCE_PIXELS = 128,
	parameter int SCALE = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  siu_pkg::cmd_t   cmd,
	output siu_pkg::sts_t   sts,
	input  logic            in_action,
	input  logic [6:0]      in_src_index,
	input  logic [31:0]     in_src_pixel,
	input  logic [9:0]      in_out_x,
	input  logic [9:0]      in_out_y,
	input  logic [7:0]      src_width,
	input  logic [7:0]      src_height,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_pixel,
	output logic            out_err
);
	import siu_pkg::*;

	localparam int AW = (MAX_SOURCE_PIXELS > 1) ? $clog2(MAX_SOURCE_PIXELS) : 1;
	localparam int BW = AW + 9;
	localparam int GW = 8 + $clog2(SCALE + 1);
	localparam int U  = 2 * SCALE;
	localparam int QW = $clog2(2 * SCALE * 256 + 2048) + 1;
	localparam int DW = 2 * QW + 2;
	localparam int SW = $clog2(4 * SCALE);
	localparam int TW = $clog2(COV_A * SCALE + COV_B + 1);
	localparam int LW = DW + 24;
	localparam int T0 = COV_A * SCALE + COV_B;

	// Source store
	logic [31:0] store_mem [MAX_SOURCE_PIXELS];
	logic        wr_en;
	logic [AW-1:0] addr_b;
	logic [BW-1:0] bsum;

	// Request and scan counters
	logic [9:0]    ox_q, oy_q;
	logic [7:0]    sx_q, sy_q;
	logic [AW-1:0] i_q;

	// Pipeline
	logic          v_s1, v_s2, v_s3;
	logic [7:0]    sx_s1, sy_s1;
	logic [31:0]   rd_a_s1, rd_b_s1;
	logic          op_l_q, op_u_q, op_ul_q;
	logic          op_cur, op_ur;
	logic [3:0]    nb;
	logic [QW-1:0] cx, cy;
	logic signed [QW-1:0] qx, qy, qx_s2, qy_s2;
	logic [31:0]   col_s2, col_s3;
	logic          op_s2, op_s3;
	logic [3:0]    nb_s2, inner_s3;
	logic signed [2*QW-1:0] qxx_s3, qyy_s3;
	logic [2*SW-1:0] ssq_s3 [4];
	logic signed [QW:0] s_val [4];
	logic [3:0]    on_seg;

	// Accumulators
	logic          any_q;
	logic [DW-1:0] best_q, dot_q;
	logic [31:0]   colour_q;
	logic [DW-1:0] d_dot, d_min;
	logic [DW-1:0] cand [4];

	// Coverage search
	logic [LW-1:0] lhs_q;
	logic [8:0]    k_q, trial_k, k_use;
	logic [3:0]    step_q;
	logic [TW-1:0] t_val;
	logic [2*TW:0] tsq2;
	logic          pass;

	// Output
	logic [16:0]   alpha_w;
	logic [7:0]    alpha;
	logic          out_valid_q, out_err_q;
	logic [31:0]   out_pixel_q;
	logic [15:0]   wh;
	logic          geom_err;

	assign wh = 16'(src_width) * 16'(src_height);
	assign geom_err = (src_width == 8'd0) || (src_height == 8'd0) ||
		(wh > 16'(MAX_SOURCE_PIXELS)) ||
		(GW'(ox_q) >= GW'(src_width) * GW'(SCALE)) ||
		(GW'(oy_q) >= GW'(src_height) * GW'(SCALE));

	assign wr_en = cmd.capture && (in_action == ACT_LOAD) &&
		({4'b0, in_src_index} < 11'(MAX_SOURCE_PIXELS));

	// Up-right neighbour sits one row back and one column on.
	assign bsum   = BW'(i_q) + BW'(1) - BW'(src_width);
	assign addr_b = bsum[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[AW'(in_src_index)] <= in_src_pixel;
		end
		if (cmd.issue) begin
			rd_a_s1 <= store_mem[i_q];
			rd_b_s1 <= store_mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ox_q <= in_out_x;
			oy_q <= in_out_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			i_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.scan_start) begin
				sx_q <= '0;
				sy_q <= '0;
				i_q  <= '0;
			end else if (cmd.issue) begin
				i_q <= i_q + AW'(1);
				if (sx_q == src_width - 8'd1) begin
					sx_q <= '0;
					sy_q <= sy_q + 8'd1;
				end else begin
					sx_q <= sx_q + 8'd1;
				end
			end
		end
	end

	assign sts.scan_last = (sx_q == src_width - 8'd1) && (sy_q == src_height - 8'd1);
	assign sts.pipe_busy = v_s1 | v_s2 | v_s3;
	assign sts.geom_err  = geom_err;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			sx_s1 <= sx_q;
			sy_s1 <= sy_q;
		end
	end

	// Stage 1: opaque flags, neighbour masks, offsets to the pixel centre.
	assign op_cur = rd_a_s1[31:24] != 8'd0;
	assign op_ur  = rd_b_s1[31:24] != 8'd0;
	assign nb[0]  = op_l_q && (sx_s1 != 8'd0);
	assign nb[1]  = op_u_q && (sy_s1 != 8'd0);
	assign nb[2]  = op_ul_q && (sx_s1 != 8'd0) && (sy_s1 != 8'd0);
	assign nb[3]  = op_ur && (sy_s1 != 8'd0) && (sx_s1 != src_width - 8'd1);
	assign cx = QW'(sx_s1) * QW'(U) + QW'(SCALE);
	assign cy = QW'(sy_s1) * QW'(U) + QW'(SCALE);
	assign qx = QW'({ox_q, 1'b1}) - cx;
	assign qy = QW'({oy_q, 1'b1}) - cy;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_l_q  <= op_cur;
			op_u_q  <= op_ur;
			op_ul_q <= op_u_q;
		end
		qx_s2  <= qx;
		qy_s2  <= qy;
		col_s2 <= rd_a_s1;
		op_s2  <= op_cur;
		nb_s2  <= nb & {4{op_cur}};
	end

	// Stage 2: squares and projections onto the four segments.
	always_comb begin
		s_val[0] = -(QW+1)'(qx_s2);
		s_val[1] = -(QW+1)'(qy_s2);
		s_val[2] = -(QW+1)'(qx_s2) - (QW+1)'(qy_s2);
		s_val[3] = (QW+1)'(qx_s2) - (QW+1)'(qy_s2);
		for (int n = 0; n < 4; n++) begin
			on_seg[n] = (s_val[n] > 0) &&
				(s_val[n] < ((n < 2) ? (QW+1)'(U) : (QW+1)'(2 * U)));
		end
	end

	always_ff @(posedge clk) begin
		qxx_s3   <= qx_s2 * qx_s2;
		qyy_s3   <= qy_s2 * qy_s2;
		for (int n = 0; n < 4; n++) begin
			ssq_s3[n] <= s_val[n][SW-1:0] * s_val[n][SW-1:0];
		end
		inner_s3 <= nb_s2 & on_seg;
		col_s3   <= col_s2;
		op_s3    <= op_s2;
	end

	// Stage 3: nearest feature and nearest dot.
	always_comb begin
		d_dot = (DW'(qxx_s3) + DW'(qyy_s3)) << 1;
		d_min = d_dot;
		for (int n = 0; n < 4; n++) begin
			cand[n] = d_dot - ((n < 2) ? (DW'(ssq_s3[n]) << 1) : DW'(ssq_s3[n]));
			if (inner_s3[n] && (cand[n] < d_min)) begin
				d_min = cand[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cmd.scan_start) begin
			any_q <= 1'b0;
		end else if (v_s3 && op_s3) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			colour_q <= '0;
		end else if (v_s3 && op_s3) begin
			if (!any_q || (d_min < best_q)) begin
				best_q <= d_min;
			end
			if (!any_q || (d_dot < dot_q)) begin
				dot_q    <= d_dot;
				colour_q <= col_s3;
			end
		end
	end

	// Coverage: binary search for the largest k, one bit a cycle.
	assign trial_k = (step_q == 4'd0) ? 9'd256 : (k_q | (9'd256 >> step_q));
	assign t_val   = TW'(T0) - TW'(trial_k) * TW'(COV_STEP);
	assign tsq2    = ((2*TW+1)'(t_val) * (2*TW+1)'(t_val)) << 1;
	assign pass    = lhs_q <= LW'(tsq2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.lhs) begin
			step_q <= '0;
		end else if (cmd.srch) begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lhs) begin
			lhs_q <= LW'(best_q) * LW'(COV_MUL);
			k_q   <= '0;
		end else if (cmd.srch && !k_q[8] && pass) begin
			k_q <= trial_k;
		end
	end

	assign sts.srch_last = step_q == 4'd8;

	// Output register
	assign k_use   = any_q ? k_q : 9'd0;
	assign alpha_w = 17'(colour_q[31:24]) * 17'(k_use) + 17'd128;
	assign alpha   = alpha_w[15:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_err_q   <= geom_err;
			out_pixel_q <= (geom_err || (alpha == 8'd0)) ? 32'd0 :
				{alpha, colour_q[23:0]};
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign out_err      = out_err_q;

endmodule

@@ sv/siu_ctrl.sv @@
`timescale 1ns / 1ps
module siu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	output logic          in_ready,
	output siu_pkg::cmd_t cmd,
	input  siu_pkg::sts_t sts
);
	import siu_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_LHS   = 3'd4;
	localparam logic [2:0] ST_SRCH  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_action == ACT_RENDER) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.geom_err) begin
					state_d = ST_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_LHS;
				end
			end
			ST_LHS: begin
				cmd.lhs = 1'b1;
				state_d = ST_SRCH;
			end
			ST_SRCH: begin
				cmd.srch = 1'b1;
				if (sts.srch_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/smooth_icon_upscaler_top.sv @@
`timescale 1ns / 1ps
// Load transaction: the next transaction is taken in the following cycle.
// Render transaction: one source pixel per cycle in the raster scan, a pipeline drain,
// a load step and a 9-step coverage search before the result is loaded.
// No transaction is taken until the result is loaded; a bad geometry goes straight to output.
// A stalled result holds the next render at its output step. Reset (arst_n low, asynchronous)
// idles the controller, empties the output register and sets both dimensions to 8.
module smooth_icon_upscaler_top #(
	parameter int MAX_SOURCE_PIXELS = 128,
	parameter int SCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata from bit 0: src_index[6:0], src_pixel[31:0], out_x[9:0], out_y[9:0], zero pad
	input  logic [63:0] s_tdata,
	// s_tuser: action (0 load, 1 render)
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: out_pixel[31:0]
	output logic [31:0] m_tdata,
	// m_tuser: geometry_error
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import siu_pkg::*;

	logic [7:0] src_width_q, src_height_q;
	cmd_t       cmd;
	sts_t       sts;

	// Configuration registers; the user must write them only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 8'd8;
			src_height_q <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The controller sequences check, scan, drain, coverage search and output.
	siu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the store, the distance pipeline and the output register.
	siu_datapath #(
		.MAX_SOURCE_PIXELS (MAX_SOURCE_PIXELS),
		.SCALE             (SCALE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (s_tuser),
		.in_src_index (s_tdata[6:0]),
		.in_src_pixel (s_tdata[38:7]),
		.in_out_x     (s_tdata[48:39]),
		.in_out_y     (s_tdata[58:49]),
		.src_width    (src_width_q),
		.src_height   (src_height_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_pixel    (m_tdata),
		.out_err      (m_tuser)
	);

endmodule

@@ sv/siu_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module siu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	`SIU_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SIU_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`SIU_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 32'd0)
	`SIU_ASSERT_IMP(a_alpha_zero, clk, arst_n, m_tvalid && (m_tdata[31:24] == 8'd0),
		m_tdata == 32'd0)
	`SIU_ASSERT_NXT(a_render_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready)
endmodule

bind smooth_icon_upscaler_top siu_checker u_siu_checker (.*);

@@ dv/smooth_icon_upscaler_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the smooth icon upscaler. Stimulus is a mix of source pixel
// loads and render requests. Each accepted render transaction is predicted by a local
// model of the distance field and coverage arithmetic. The prediction is queued and then
// compared with the next result transaction on the master side.
module smooth_icon_upscaler_top_tb;
	import siu_pkg::*;

	localparam int MAX_PIX = 128;
	localparam int SCALE = 8;
	// Settling pause before register writes.
	localparam int SETTLE_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	typedef struct packed {
		logic [31:0] pixel;
		logic        geom_err;
	} render_result_t;

	// Local copies of the icon store and of the two dimension registers.
	logic [31:0]    icon_mem [MAX_PIX];
	int             icon_w;
	int             icon_h;
	render_result_t pending_renders[$];
	int             mismatches;
	int             burst_left;
	int unsigned    stall_cnt;

	smooth_icon_upscaler_top #(
		.MAX_SOURCE_PIXELS(MAX_PIX),
		.SCALE(SCALE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Doubled squared distance from an offset (qx, qy) to the segment towards a neighbour.
	function automatic longint seg_dist2(longint qx, longint qy, int dx, int dy);
		longint len;
		longint s;
		longint q2;
		longint rx;
		longint ry;
		len = dx * dx + dy * dy;
		s = qx * dx + qy * dy;
		q2 = qx * qx + qy * qy;
		if (s <= 0) begin
			return 2 * q2;
		end
		if (s >= 2 * SCALE * len) begin
			rx = qx - 2 * SCALE * dx;
			ry = qy - 2 * SCALE * dy;
			return 2 * (rx * rx + ry * ry);
		end
		return 2 * q2 - ((len == 1) ? 2 * s * s : s * s);
	endfunction

	// Largest Q.8 coverage whose edge distance still reaches the point.
	function automatic int edge_coverage(longint d2);
		longint unsigned lhs;
		longint unsigned t;
		lhs = longint'(d2) * COV_MUL;
		for (int k = 256; k > 0; k--) begin
			t = COV_A * SCALE + COV_B - COV_STEP * k;
			if (lhs <= 2 * t * t) begin
				return k;
			end
		end
		return 0;
	endfunction

	function automatic render_result_t render_pixel(int ox, int oy);
		render_result_t r;
		longint px;
		longint py;
		longint qx;
		longint qy;
		longint d;
		longint d2;
		longint best;
		longint dot_best;
		bit any;
		bit dot_any;
		logic [31:0] src;
		logic [31:0] colour;
		int nx;
		int ny;
		int k;
		int alpha;
		int ndx [4];
		int ndy [4];
		ndx = '{1, 0, 1, 1};
		ndy = '{0, 1, 1, -1};
		r = '0;
		if (icon_w == 0 || icon_h == 0 || icon_w * icon_h > MAX_PIX ||
				ox >= icon_w * SCALE || oy >= icon_h * SCALE) begin
			r.geom_err = 1'b1;
			return r;
		end
		px = 2 * ox + 1;
		py = 2 * oy + 1;
		any = 0;
		dot_any = 0;
		best = 0;
		dot_best = 0;
		colour = '0;
		for (int sy = 0; sy < icon_h; sy++) begin
			for (int sx = 0; sx < icon_w; sx++) begin
				src = icon_mem[sy * icon_w + sx];
				if (src[31:24] != 8'd0) begin
					qx = px - (2 * SCALE * sx + SCALE);
					qy = py - (2 * SCALE * sy + SCALE);
					d = 2 * (qx * qx + qy * qy);
					if (!dot_any || d < dot_best) begin
						dot_any = 1;
						dot_best = d;
						colour = src;
					end
					for (int n = 0; n < 4; n++) begin
						nx = sx + ndx[n];
						ny = sy + ndy[n];
						if (nx >= 0 && nx < icon_w && ny >= 0 && ny < icon_h &&
								icon_mem[ny * icon_w + nx][31:24] != 8'd0) begin
							d2 = seg_dist2(qx, qy, ndx[n], ndy[n]);
							if (d2 < d) begin
								d = d2;
							end
						end
					end
					if (!any || d < best) begin
						any = 1;
						best = d;
					end
				end
			end
		end
		k = any ? edge_coverage(best) : 0;
		alpha = (int'(colour[31:24]) * k + 128) >> 8;
		if (alpha != 0) begin
			r.pixel = {alpha[7:0], colour[23:0]};
		end
		return r;
	endfunction

	// Sends one item; the sender works in bursts separated by random gaps. The prediction
	// is made at the edge that accepts the transaction, so it sees the store in order.
	task automatic send_item(logic act, int idx, logic [31:0] pix, int ox, int oy);
		logic [9:0] x10;
		logic [9:0] y10;
		logic [6:0] i7;
		x10 = ox[9:0];
		y10 = oy[9:0];
		i7 = idx[6:0];
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, y10, x10, pix, i7};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (act == ACT_LOAD) begin
			icon_mem[i7] = pix;
		end else begin
			pending_renders.push_back(render_pixel(x10, y10));
		end
	endtask

	task automatic idle_sender();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every queued render to come back, then lets the block settle.
	task automatic drain();
		idle_sender();
		while (pending_renders.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SRC_WIDTH) begin
			icon_w = val & 8'hff;
		end else begin
			icon_h = val & 8'hff;
		end
	endtask

	task automatic set_geometry(int w, int h);
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
	endtask

	// A random opaque-or-clear source pixel; about two in five are fully transparent.
	function automatic logic [31:0] rand_src();
		logic [31:0] p;
		p = $urandom;
		if ($urandom_range(0, 4) < 2) begin
			p[31:24] = 8'd0;
		end
		return p;
	endfunction

	task automatic test_fill_store();
		// Every entry is loaded before any render, so no unwritten entry is ever read.
		for (int i = 0; i < MAX_PIX; i++) begin
			send_item(ACT_LOAD, i, (i % 3 == 0) ? 32'h0 : rand_src(), $urandom, $urandom);
		end
	endtask

	task automatic test_directed();
		// Default 8x8 geometry: two opposite corners, the first pixel past the right and bottom edges and far outside.
		send_item(ACT_RENDER, 0, 32'hffffffff, 0, 0);
		send_item(ACT_RENDER, 0, 32'h0, 63, 63);
		send_item(ACT_RENDER, 0, 32'h0, 64, 0);
		send_item(ACT_RENDER, 0, 32'h0, 0, 64);
		send_item(ACT_RENDER, 127, 32'h0, 1023, 1023);
		// Extreme source values: fully opaque white, alpha of one, and all zeros.
		send_item(ACT_LOAD, 0, 32'hffffffff, 0, 0);
		send_item(ACT_LOAD, 9, 32'h01abcdef, 0, 0);
		send_item(ACT_LOAD, 127, 32'h0, 1023, 1023);
		send_item(ACT_RENDER, 0, 32'h0, 4, 4);
		send_item(ACT_RENDER, 0, 32'h0, 12, 12);
		send_item(ACT_RENDER, 0, 32'h0, 7, 7);
		// Two dots with a clear pixel between them; both renders lie nearer the left dot.
		send_item(ACT_LOAD, 18, 32'h80112233, 0, 0);
		send_item(ACT_LOAD, 20, 32'h80445566, 0, 0);
		send_item(ACT_LOAD, 19, 32'h00000000, 0, 0);
		send_item(ACT_RENDER, 0, 32'h0, 23, 19);
		send_item(ACT_RENDER, 0, 32'h0, 24, 20);
		// An icon with no opaque pixel at all renders as zero everywhere.
		for (int i = 0; i < 4; i++) begin
			send_item(ACT_LOAD, i, 32'h00ffffff, 0, 0);
		end
		set_geometry(2, 2);
		send_item(ACT_RENDER, 0, 32'h0, 7, 8);
		send_item(ACT_RENDER, 0, 32'h0, 15, 15);
		// Bad geometry: a zero dimension and an area above the store size.
		set_geometry(0, 8);
		send_item(ACT_RENDER, 0, 32'h0, 0, 0);
		set_geometry(129, 1);
		send_item(ACT_RENDER, 0, 32'h0, 0, 0);
		set_geometry(255, 255);
		send_item(ACT_RENDER, 0, 32'h0, 3, 3);
	endtask

	// One random phase on a given geometry: mostly loads inside the icon and renders inside
	// the enlarged image, with a few loads elsewhere and renders anywhere in the field range.
	task automatic test_random_phase(int w, int h, int items);
		int area;
		int sel;
		set_geometry(w, h);
		area = (w * h > MAX_PIX) ? MAX_PIX : w * h;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				send_item(ACT_LOAD, $urandom_range(0, area - 1), rand_src(), $urandom, $urandom);
			end else if (sel < 35) begin
				send_item(ACT_LOAD, $urandom_range(0, 127), rand_src(), $urandom, $urandom);
			end else if (sel < 90) begin
				send_item(ACT_RENDER, $urandom, $urandom, $urandom_range(0, w * SCALE - 1),
					$urandom_range(0, h * SCALE - 1));
			end else begin
				send_item(ACT_RENDER, $urandom, $urandom, $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			end
			if ($urandom_range(0, 149) == 0) begin
				drain();
			end
		end
	endtask

	task automatic test_random();
		test_random_phase(8, 8, 200);
		test_random_phase(1, 128, 180);
		test_random_phase(128, 1, 180);
		test_random_phase(1, 1, 100);
		test_random_phase(16, 8, 200);
		// The sender holds off here until the last render has come back.
		drain();
		test_random_phase(11, 11, 200);
		test_random_phase(3, 5, 150);
		test_random_phase(12, 10, 160);
		test_random_phase(9, 15, 60);
	endtask

	// The receiver steps its stall pattern with bits 9:8 of a free-running counter: always ready, random,
	// mostly stalled, and long stalls with short openings.
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		case (stall_cnt[9:8])
			2'd0: begin
				m_tready <= 1'b1;
			end
			2'd1: begin
				m_tready <= $urandom_range(0, 1);
			end
			2'd2: begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				m_tready <= (stall_cnt[5:0] < 6'd8);
			end
		endcase
	end

	// Each result transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		render_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_renders.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: pixel %08h error %0b", m_tdata, m_tuser);
				end
			end else begin
				exp_r = pending_renders.pop_front();
				if (m_tdata !== exp_r.pixel || m_tuser !== exp_r.geom_err) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected pixel %08h error %0b, got %08h error %0b",
							exp_r.pixel, exp_r.geom_err, m_tdata, m_tuser);
					end
				end
			end
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_LOAD;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= '0;
		stall_cnt <= '0;
		arst_n = 1'b0;
		mismatches = 0;
		burst_left = 0;
		icon_w = 8;
		icon_h = 8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_store();
		test_directed();
		test_random();
		drain();
		if (mismatches == 0 && pending_renders.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Time limit: the run is reported as failed if it has not finished by then.
	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
